@@ design/abbf_pkg.sv @@
// Shared constants and codes for the alpha bounding box finder.
package abbf_pkg;

  // Fixed field widths of the channels
  localparam int ALPHA_W   = 8;
  localparam int CFG_DW    = 13;
  localparam int CFG_IDX_W = 4;
  localparam int COORD_W   = 12;
  localparam int SIZE_W    = 13;

  // Frame size after reset
  localparam logic [CFG_DW-1:0] FRAME_DIM_RESET = 13'd4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_TOL = 4'd0,
    CFG_PAD       = 4'd1,
    CFG_WIDTH     = 4'd2,
    CFG_HEIGHT    = 4'd3
  } cfg_idx_t;

endpackage

@@ design/abbf_pix_if.sv @@
// Pixel input channel: valid/ready with the alpha byte.
interface abbf_pix_if
  import abbf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha_value;

  modport source (output valid, output alpha_value, input ready);
  modport sink   (input valid, input alpha_value, output ready);
endinterface

@@ design/abbf_box_if.sv @@
// Result channel: valid/ready with the padded crop box.
interface abbf_box_if
  import abbf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] box_left;
  logic [COORD_W-1:0] box_top;
  logic [COORD_W-1:0] box_right;
  logic [COORD_W-1:0] box_bottom;
  logic [SIZE_W-1:0]  crop_width;
  logic [SIZE_W-1:0]  crop_height;
  logic               any_opaque;

  modport source (output valid, output box_left, output box_top, output box_right,
                  output box_bottom, output crop_width, output crop_height,
                  output any_opaque, input ready);
  modport sink   (input valid, input box_left, input box_top, input box_right,
                  input box_bottom, input crop_width, input crop_height,
                  input any_opaque, output ready);
endinterface

@@ design/abbf_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
interface abbf_cfg_if
  import abbf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DW-1:0]    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ design/abbf_tracker.sv @@
// Pixel register, raster counters and opaque-extent tracking.
module abbf_tracker
  import abbf_pkg::*;
#(
  parameter int MAX_DIM = 4096,
  parameter int CW      = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  abbf_pix_if.sink           in_pix,
  input  logic [ALPHA_W-1:0] alpha_tol,
  input  logic [CW-1:0]      last_col,
  input  logic [CW-1:0]      last_rw,
  output logic               snap_valid,
  input  logic               snap_ready,
  output logic [CW-1:0]      snap_min_col,
  output logic [CW-1:0]      snap_max_col,
  output logic [CW-1:0]      snap_first_row,
  output logic [CW-1:0]      snap_last_row,
  output logic               snap_seen
);

  localparam logic [CW-1:0] MIN_COL_RESET = CW'(MAX_DIM - 1);

  logic               pix_valid_r;
  logic [ALPHA_W-1:0] pix_alpha_r;
  logic [CW-1:0]      col_r, col_nxt;
  logic [CW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      min_col_r, min_col_nxt;
  logic [CW-1:0]      max_col_r, max_col_nxt;
  logic [CW-1:0]      first_row_r, first_row_nxt;
  logic [CW-1:0]      last_row_r, last_row_nxt;
  logic               seen_r, seen_nxt;
  logic               snap_valid_r;
  logic [CW-1:0]      snap_min_col_r, snap_max_col_r;
  logic [CW-1:0]      snap_first_row_r, snap_last_row_r;
  logic               snap_seen_r;

  logic opaque;
  logic col_end;
  logic row_end;
  logic frame_end;
  logic advance;
  logic [CW-1:0] upd_min_col, upd_max_col, upd_first_row, upd_last_row;
  logic          upd_seen;

  // Advance the held pixel unless its frame result has nowhere to go
  assign col_end   = (col_r >= last_col);
  assign row_end   = (row_r >= last_rw);
  assign frame_end = col_end && row_end;
  assign advance   = pix_valid_r && (!frame_end || !snap_valid_r || snap_ready);
  assign in_pix.ready = !pix_valid_r || advance;

  // Fold the held pixel into the extent
  always_comb begin
    opaque        = (pix_alpha_r > alpha_tol);
    upd_min_col   = min_col_r;
    upd_max_col   = max_col_r;
    upd_first_row = first_row_r;
    upd_last_row  = last_row_r;
    upd_seen      = seen_r;
    if (opaque) begin
      if (!seen_r) begin
        upd_first_row = row_r;
        upd_min_col   = col_r;
        upd_max_col   = col_r;
      end else begin
        if (col_r < min_col_r) begin
          upd_min_col = col_r;
        end
        if (col_r > max_col_r) begin
          upd_max_col = col_r;
        end
      end
      upd_last_row = row_r;
      upd_seen     = 1'b1;
    end
  end

  // Step the counters; clear tracking at the end of a frame
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    min_col_nxt   = min_col_r;
    max_col_nxt   = max_col_r;
    first_row_nxt = first_row_r;
    last_row_nxt  = last_row_r;
    seen_nxt      = seen_r;
    if (advance) begin
      if (frame_end) begin
        col_nxt       = '0;
        row_nxt       = '0;
        min_col_nxt   = MIN_COL_RESET;
        max_col_nxt   = '0;
        first_row_nxt = '0;
        last_row_nxt  = '0;
        seen_nxt      = 1'b0;
      end else begin
        col_nxt       = col_end ? '0 : col_r + CW'(1);
        row_nxt       = col_end ? row_r + CW'(1) : row_r;
        min_col_nxt   = upd_min_col;
        max_col_nxt   = upd_max_col;
        first_row_nxt = upd_first_row;
        last_row_nxt  = upd_last_row;
        seen_nxt      = upd_seen;
      end
    end
  end

  // Hold the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_pix.ready) begin
      pix_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.ready && in_pix.valid) begin
      pix_alpha_r <= in_pix.alpha_value;
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      min_col_r   <= MIN_COL_RESET;
      max_col_r   <= '0;
      first_row_r <= '0;
      last_row_r  <= '0;
      seen_r      <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      min_col_r   <= min_col_nxt;
      max_col_r   <= max_col_nxt;
      first_row_r <= first_row_nxt;
      last_row_r  <= last_row_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // Capture the finished frame's extent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (advance && frame_end) begin
      snap_valid_r <= 1'b1;
    end else if (snap_ready) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_end) begin
      snap_min_col_r   <= upd_min_col;
      snap_max_col_r   <= upd_max_col;
      snap_first_row_r <= upd_first_row;
      snap_last_row_r  <= upd_last_row;
      snap_seen_r      <= upd_seen;
    end
  end

  assign snap_valid     = snap_valid_r;
  assign snap_min_col   = snap_min_col_r;
  assign snap_max_col   = snap_max_col_r;
  assign snap_first_row = snap_first_row_r;
  assign snap_last_row  = snap_last_row_r;
  assign snap_seen      = snap_seen_r;

  // Once an opaque pixel is seen the extent is ordered
  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (min_col_r <= max_col_r))
    else $error("tracked column extent out of order");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (first_row_r <= last_row_r))
    else $error("tracked row extent out of order");

endmodule

@@ design/abbf_box.sv @@
// Padding, clamping and crop size of a finished frame, into the result register.
module abbf_box
  import abbf_pkg::*;
#(
  parameter int CW = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              snap_valid,
  output logic              snap_ready,
  input  logic [CW-1:0]     snap_min_col,
  input  logic [CW-1:0]     snap_max_col,
  input  logic [CW-1:0]     snap_first_row,
  input  logic [CW-1:0]     snap_last_row,
  input  logic              snap_seen,
  input  logic [CFG_DW-1:0] pad,
  input  logic [CW-1:0]     last_col,
  input  logic [CW-1:0]     last_rw,
  abbf_box_if.source        out_box
);

  localparam int DW = CW + 1;
  localparam int SW = ((CW > CFG_DW) ? CW : CFG_DW) + 1;

  logic               out_valid_r;
  logic [CW-1:0]      left_r, top_r, right_r, bottom_r;
  logic [DW-1:0]      crop_w_r, crop_h_r;
  logic               any_opaque_r;

  logic [CW-1:0] left_c, top_c, right_c, bottom_c;
  logic [DW-1:0] crop_w_c, crop_h_c;
  logic          load;

  // Low edge: subtract the padding, floor at zero, cap at the last index
  function automatic logic [CW-1:0] low_edge(input logic [CW-1:0] v,
                                             input logic [CFG_DW-1:0] p,
                                             input logic [CW-1:0] lim);
    logic [SW-1:0] vx;
    logic [SW-1:0] px;
    logic [SW-1:0] d;
    vx = SW'(v);
    px = SW'(p);
    d  = (vx > px) ? vx - px : '0;
    return (d < SW'(lim)) ? CW'(d) : lim;
  endfunction

  // High edge: add the padding, cap at the last index
  function automatic logic [CW-1:0] high_edge(input logic [CW-1:0] v,
                                              input logic [CFG_DW-1:0] p,
                                              input logic [CW-1:0] lim);
    logic [SW-1:0] s;
    s = SW'(v) + SW'(p);
    return (s > SW'(lim)) ? lim : CW'(s);
  endfunction

  // Box of the frame; whole image when nothing was opaque
  always_comb begin
    if (snap_seen) begin
      left_c   = low_edge(snap_min_col, pad, last_col);
      top_c    = low_edge(snap_first_row, pad, last_rw);
      right_c  = high_edge(snap_max_col, pad, last_col);
      bottom_c = high_edge(snap_last_row, pad, last_rw);
    end else begin
      left_c   = '0;
      top_c    = '0;
      right_c  = last_col;
      bottom_c = last_rw;
    end
    crop_w_c = DW'(right_c) - DW'(left_c) + DW'(1);
    crop_h_c = DW'(bottom_c) - DW'(top_c) + DW'(1);
  end

  // Take a new frame while the result register is free or being drained
  assign snap_ready = !out_valid_r || out_box.ready;
  assign load       = snap_valid && snap_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r       <= left_c;
      top_r        <= top_c;
      right_r      <= right_c;
      bottom_r     <= bottom_c;
      crop_w_r     <= crop_w_c;
      crop_h_r     <= crop_h_c;
      any_opaque_r <= snap_seen;
    end
  end

  assign out_box.valid       = out_valid_r;
  assign out_box.box_left    = COORD_W'(left_r);
  assign out_box.box_top     = COORD_W'(top_r);
  assign out_box.box_right   = COORD_W'(right_r);
  assign out_box.box_bottom  = COORD_W'(bottom_r);
  assign out_box.crop_width  = SIZE_W'(crop_w_r);
  assign out_box.crop_height = SIZE_W'(crop_h_r);
  assign out_box.any_opaque  = any_opaque_r;

  // The box never turns inside out
  a_box_h_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (left_r <= right_r))
    else $error("result box left edge beyond right edge");

  a_box_v_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (top_r <= bottom_r))
    else $error("result box top edge below bottom edge");

endmodule

@@ design/alpha_bounding_box_finder_top.sv @@
// Top level of the alpha bounding box finder: configuration and stage wiring.
//
// Usage:
//   in_pix  : one alpha byte per item, raster order, valid/ready.
//   out_box : one item per frame, the padded and clamped box of opaque
//             pixels (alpha above the tolerance), its crop size and a flag
//             that tells whether any pixel was opaque (else the whole image).
//   cfg_wr  : register writes (0 tolerance, 1 padding, 2 width, 3 height);
//             always ready, write only while the block is idle.
// Throughput: one pixel per cycle while the input is not stalled, set by the
//   counter and extent update in the tracker stage.
// Result path: once the last pixel of a frame is in the pixel register, its
//   extent goes to the capture register and then to the result register.
// Reset: counters and extent clear, tolerance and padding go to 0, frame
//   size to 4096 by 4096.
// Stall: a held result waits in the output register; pixels keep flowing
//   and one more finished frame can wait in the capture register; the input
//   stalls once the last pixel of the frame after that sits in the pixel
//   register.
module alpha_bounding_box_finder_top
  import abbf_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  abbf_pix_if.sink   in_pix,
  abbf_box_if.source out_box,
  abbf_cfg_if.sink   cfg_wr
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int EW = (DW > CFG_DW) ? DW : CFG_DW;

  logic [ALPHA_W-1:0] alpha_tol_r;
  logic [CFG_DW-1:0]  pad_r;
  logic [CFG_DW-1:0]  frame_w_r;
  logic [CFG_DW-1:0]  frame_h_r;

  logic [EW-1:0] w_ext, h_ext, w_eff, h_eff;
  logic [CW-1:0] last_col, last_rw;

  logic          snap_valid, snap_ready, snap_seen;
  logic [CW-1:0] snap_min_col, snap_max_col, snap_first_row, snap_last_row;

  // Register writes; unknown indexes drop
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_tol_r <= '0;
      pad_r       <= '0;
      frame_w_r   <= FRAME_DIM_RESET;
      frame_h_r   <= FRAME_DIM_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.reg_index)
        CFG_ALPHA_TOL: alpha_tol_r <= cfg_wr.wr_data[ALPHA_W-1:0];
        CFG_PAD:       pad_r       <= cfg_wr.wr_data;
        CFG_WIDTH:     frame_w_r   <= cfg_wr.wr_data;
        CFG_HEIGHT:    frame_h_r   <= cfg_wr.wr_data;
        default:       ;
      endcase
    end
  end

  // Effective frame size: zero reads as one, oversize caps at the maximum
  always_comb begin
    w_ext = EW'(frame_w_r);
    h_ext = EW'(frame_h_r);
    priority if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = w_ext;
    end
    priority if (h_ext == '0) begin
      h_eff = EW'(1);
    end else if (h_ext > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = h_ext;
    end
    last_col = CW'(w_eff - EW'(1));
    last_rw  = CW'(h_eff - EW'(1));
  end

  abbf_tracker #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pix         (in_pix),
    .alpha_tol      (alpha_tol_r),
    .last_col       (last_col),
    .last_rw        (last_rw),
    .snap_valid     (snap_valid),
    .snap_ready     (snap_ready),
    .snap_min_col   (snap_min_col),
    .snap_max_col   (snap_max_col),
    .snap_first_row (snap_first_row),
    .snap_last_row  (snap_last_row),
    .snap_seen      (snap_seen)
  );

  abbf_box #(
    .CW (CW)
  ) u_box (
    .clk            (clk),
    .rst_n          (rst_n),
    .snap_valid     (snap_valid),
    .snap_ready     (snap_ready),
    .snap_min_col   (snap_min_col),
    .snap_max_col   (snap_max_col),
    .snap_first_row (snap_first_row),
    .snap_last_row  (snap_last_row),
    .snap_seen      (snap_seen),
    .pad            (pad_r),
    .last_col       (last_col),
    .last_rw        (last_rw),
    .out_box        (out_box)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench: alpha bounding box finder against a cycle-free box predictor.
`timescale 1ns / 100ps

module testbench;
  import abbf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 1400;
  localparam int DIM_MAX       = 4096;
  // Register index that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd9;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic               opaque;
  } crop_box_t;

  // One directed frame: setting, pixels (first pixel in the low byte), known box
  typedef struct packed {
    logic [CFG_DW-1:0] tol;
    logic [CFG_DW-1:0] pad;
    logic [CFG_DW-1:0] wdt;
    logic [CFG_DW-1:0] hgt;
    logic [3:0]        n_pix;
    logic [63:0]       pix;
    logic              known;
    crop_box_t         box;
  } frame_row_t;

  logic clk;
  logic rst_n;

  abbf_pix_if pix_if ();
  abbf_box_if box_if ();
  abbf_cfg_if cfg_if ();

  alpha_bounding_box_finder_top #(
    .MAX_DIM(DIM_MAX)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_box(box_if),
    .cfg_wr (cfg_if)
  );

  // Register mirror
  logic [ALPHA_W-1:0] cfg_tol;
  logic [CFG_DW-1:0]  cfg_pad;
  logic [CFG_DW-1:0]  cfg_w;
  logic [CFG_DW-1:0]  cfg_h;

  // Raster position and extent of opaque pixels in the current frame
  logic [COORD_W-1:0] col_cnt;
  logic [COORD_W-1:0] row_cnt;
  logic [COORD_W-1:0] min_col;
  logic [COORD_W-1:0] max_col;
  logic [COORD_W-1:0] top_row;
  logic [COORD_W-1:0] bot_row;
  logic               any_seen;

  crop_box_t  expected_boxes[$];
  frame_row_t directed_rows[7];

  int fail_count;
  int cycle_count;
  int burst_left;
  int gap_max;
  int stall_mode;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned clip_dim(input logic [CFG_DW-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return 32'(v);
  endfunction

  task automatic clear_extent();
    col_cnt  = '0;
    row_cnt  = '0;
    min_col  = '1;
    max_col  = '0;
    top_row  = '0;
    bot_row  = '0;
    any_seen = 1'b0;
  endtask

  // Advance the raster position by one pixel; queue the box at the end of a frame
  task automatic track_pixel(input logic [ALPHA_W-1:0] a);
    int unsigned lc, lr, l, t, r, b;
    crop_box_t bx;
    lc = clip_dim(cfg_w) - 1;
    lr = clip_dim(cfg_h) - 1;
    if (a > cfg_tol) begin
      if (!any_seen) begin
        top_row = row_cnt;
        min_col = col_cnt;
        max_col = col_cnt;
      end
      bot_row = row_cnt;
      if (col_cnt < min_col) min_col = col_cnt;
      if (col_cnt > max_col) max_col = col_cnt;
      any_seen = 1'b1;
    end
    if (col_cnt < lc) begin
      col_cnt = col_cnt + 1'b1;
    end else begin
      col_cnt = '0;
      if (row_cnt < lr) begin
        row_cnt = row_cnt + 1'b1;
      end else begin
        if (any_seen) begin
          // Pad on every side, saturate at the image edges
          l = (min_col > cfg_pad) ? 32'(min_col) - 32'(cfg_pad) : 0;
          t = (top_row > cfg_pad) ? 32'(top_row) - 32'(cfg_pad) : 0;
          if (l > lc) l = lc;
          if (t > lr) t = lr;
          r = 32'(max_col) + 32'(cfg_pad);
          b = 32'(bot_row) + 32'(cfg_pad);
          if (r > lc) r = lc;
          if (b > lr) b = lr;
        end else begin
          l = 0;
          t = 0;
          r = lc;
          b = lr;
        end
        bx.left   = l[COORD_W-1:0];
        bx.top    = t[COORD_W-1:0];
        bx.right  = r[COORD_W-1:0];
        bx.bottom = b[COORD_W-1:0];
        bx.width  = SIZE_W'(r - l + 1);
        bx.height = SIZE_W'(b - t + 1);
        bx.opaque = any_seen;
        expected_boxes.push_back(bx);
        clear_extent();
      end
    end
  endtask

  // Send one pixel; open a new burst after a random gap when the old one runs out
  task automatic push_pixel(input logic [ALPHA_W-1:0] a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pix_if.valid       <= 1'b1;
    pix_if.alpha_value <= a;
    do @(posedge clk); while (!pix_if.ready);
    burst_left--;
    track_pixel(a);
  endtask

  // Hold the config write valid across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_ALPHA_TOL: cfg_tol = data[ALPHA_W-1:0];
      CFG_PAD:       cfg_pad = data;
      CFG_WIDTH:     cfg_w   = data;
      CFG_HEIGHT:    cfg_h   = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DW-1:0] tol, input logic [CFG_DW-1:0] pad,
                               input logic [CFG_DW-1:0] wdt, input logic [CFG_DW-1:0] hgt,
                               input bit spare);
    write_reg(CFG_ALPHA_TOL, tol);
    write_reg(CFG_PAD, pad);
    write_reg(CFG_WIDTH, wdt);
    write_reg(CFG_HEIGHT, hgt);
    if (spare) write_reg(CFG_SPARE_IDX, '1);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop input valid, drain every pending box, then let the pipeline settle
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Result side: compare each box with the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    crop_box_t exp_box;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst_n) begin
      box_if.ready <= 1'b0;
    end else begin
      if (box_if.valid && box_if.ready) begin
        if (expected_boxes.size() == 0) begin
          $display("%0t: box with no expectation, expected none, got %0d %0d %0d %0d",
                   $time, box_if.box_left, box_if.box_top, box_if.box_right,
                   box_if.box_bottom);
          fail_count++;
        end else begin
          exp_box = expected_boxes.pop_front();
          check_field("box_left", exp_box.left, box_if.box_left);
          check_field("box_top", exp_box.top, box_if.box_top);
          check_field("box_right", exp_box.right, box_if.box_right);
          check_field("box_bottom", exp_box.bottom, box_if.box_bottom);
          check_field("crop_width", exp_box.width, box_if.crop_width);
          check_field("crop_height", exp_box.height, box_if.crop_height);
          check_field("any_opaque", exp_box.opaque, box_if.any_opaque);
        end
      end
      if (cycle_count[6:0] == 7'd0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       box_if.ready <= 1'b1;
        1:       box_if.ready <= ($urandom_range(0, 3) != 0);
        2:       box_if.ready <= ($urandom_range(0, 3) == 0);
        default: box_if.ready <= (cycle_count[2:0] == 3'd0);
      endcase
    end
  end

  initial begin
    frame_row_t row;
    int random_pixels, phase_no, large_done, n_pix, frame_px, pct, roll;
    logic [ALPHA_W-1:0] tol8, a;
    logic [CFG_DW-1:0] tol_d, pad_d, w_d, h_d;

    rst_n              = 1'b0;
    pix_if.valid       = 1'b0;
    pix_if.alpha_value = '0;
    box_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.reg_index   = CFG_ALPHA_TOL;
    cfg_if.wr_data     = '0;
    fail_count         = 0;
    cycle_count        = 0;
    burst_left         = 0;
    gap_max            = 2;
    stall_mode         = 0;
    cfg_tol            = '0;
    cfg_pad            = '0;
    cfg_w              = FRAME_DIM_RESET;
    cfg_h              = FRAME_DIM_RESET;
    clear_extent();

    // Directed frames: tol, pad, width, height, pixel count, pixels, known, box
    directed_rows[0] = '{13'd0, 13'd0, 13'd1, 13'd1, 4'd1, 64'h00, 1'b1,
                         '{12'd0, 12'd0, 12'd0, 12'd0, 13'd1, 13'd1, 1'b0}};
    directed_rows[1] = '{13'd0, 13'd0, 13'd1, 13'd1, 4'd1, 64'hFF, 1'b1,
                         '{12'd0, 12'd0, 12'd0, 12'd0, 13'd1, 13'd1, 1'b1}};
    // Zero frame size reads as one pixel
    directed_rows[2] = '{13'd0, 13'd0, 13'd0, 13'd0, 4'd1, 64'h01, 1'b1,
                         '{12'd0, 12'd0, 12'd0, 12'd0, 13'd1, 13'd1, 1'b1}};
    // Tolerance 255: nothing is opaque, whole image
    directed_rows[3] = '{13'h1FFF, 13'd0, 13'd2, 13'd2, 4'd4, 64'hFFFF_FFFF, 1'b1,
                         '{12'd0, 12'd0, 12'd1, 12'd1, 13'd2, 13'd2, 1'b0}};
    // Tolerance 254: only 255 counts
    directed_rows[4] = '{13'd254, 13'd0, 13'd2, 13'd2, 4'd4, 64'hFEFE_FFFE, 1'b1,
                         '{12'd1, 12'd0, 12'd1, 12'd0, 13'd1, 13'd1, 1'b1}};
    // Huge padding saturates at every edge
    directed_rows[5] = '{13'd128, 13'h1FFF, 13'd3, 13'd2, 4'd6, 64'h8100, 1'b1,
                         '{12'd0, 12'd0, 12'd2, 12'd1, 13'd3, 13'd2, 1'b1}};
    directed_rows[6] = '{13'd0, 13'd1, 13'd4, 13'd2, 4'd8, 64'h0000_0001_0100_0000, 1'b1,
                         '{12'd0, 12'd0, 12'd3, 12'd1, 13'd4, 13'd2, 1'b1}};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      wait_idle();
      apply_setting(row.tol, row.pad, row.wdt, row.hgt, i == 0);
      for (int p = 0; p < row.n_pix; p++) push_pixel(row.pix[8*p +: 8]);
      // Check the hand-worked box rather than the predicted one
      if (row.known) expected_boxes[$] = row.box;
    end

    // Random phases: new setting, then whole frames, sometimes cut mid-frame
    random_pixels = 0;
    phase_no      = 0;
    large_done    = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      phase_no++;
      // Hold the sender until every pending box has come back
      wait_idle();

      tol8 = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 10) tol8 = 8'd0;
      else if (roll < 20) tol8 = 8'($urandom_range(253, 255));
      tol_d = {5'($urandom_range(0, 31)), tol8};

      roll = $urandom_range(0, 99);
      if (roll < 60) pad_d = 13'($urandom_range(0, 3));
      else if (roll < 80) pad_d = 13'($urandom_range(0, 12));
      else if (roll < 90) pad_d = 13'(DIM_MAX);
      else pad_d = 13'($urandom_range(0, 8191));

      if (phase_no % 10 == 5 && large_done < 4) begin
        // A few slices of frames at the largest sizes, and sizes beyond them
        case (large_done)
          0:       begin w_d = 13'h1FFF;       h_d = 13'd1;         end
          1:       begin w_d = 13'd1;          h_d = 13'(DIM_MAX);  end
          2:       begin w_d = 13'(DIM_MAX);   h_d = 13'd1;         end
          default: begin w_d = 13'd0;          h_d = 13'h1FFF;      end
        endcase
        large_done++;
      end else begin
        w_d = 13'($urandom_range(1, 8));
        h_d = 13'($urandom_range(1, 6));
        if ($urandom_range(0, 19) == 0) w_d = '0;
        if ($urandom_range(0, 19) == 0) h_d = '0;
      end
      apply_setting(tol_d, pad_d, w_d, h_d, $urandom_range(0, 9) == 0);

      frame_px = clip_dim(w_d) * clip_dim(h_d);
      if (frame_px >= DIM_MAX) begin
        // Too long to finish: send a slice and let the next setting cut the frame
        n_pix = $urandom_range(32, 96);
      end else begin
        n_pix = $urandom_range(1, 4) * frame_px;
        // Leave the frame unfinished so the next setting lands mid-frame
        if (frame_px > 1 && $urandom_range(0, 99) < 30)
          n_pix += $urandom_range(1, frame_px - 1);
      end

      case ($urandom_range(0, 3))
        0:       pct = 2;
        1:       pct = 10;
        2:       pct = 40;
        default: pct = 90;
      endcase
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);

      for (int k = 0; k < n_pix; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) a = 8'($urandom_range(0, 255));
        else if (roll < 10 + pct) a = (cfg_tol == 8'hFF) ? 8'hFF :
                                      8'($urandom_range(int'(cfg_tol) + 1, 255));
        else a = 8'($urandom_range(0, cfg_tol));
        push_pixel(a);
      end
      random_pixels += n_pix;
    end

    // Drain, then let the pipeline go quiet before the verdict
    wait_idle();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
